### hdl/vcf_pkg.sv
// Shared types, codes and limits for the validated command FIFO.
// Used by vcf_front, vcf_back and the top level; depends on nothing.
package vcf_pkg;

  localparam int QUEUE_DEPTH = 16;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_INVALID = 2'd1;
  localparam logic [1:0] STATUS_FULL    = 2'd2;
  localparam logic [1:0] STATUS_EMPTY   = 2'd3;

  localparam logic [1:0] CMD_SETUP  = 2'd0;
  localparam logic [1:0] CMD_SWITCH = 2'd1;
  localparam logic [1:0] CMD_HALT   = 2'd2;

  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  localparam logic [7:0] LEVEL_MAX   = 8'd100;
  localparam logic [7:0] TIME_MAX    = 8'd240;
  localparam logic [7:0] SWITCH_MAX  = 8'd1;
  localparam logic [7:0] CHANNEL_MAX = 8'd7;

  typedef struct packed {
    logic [1:0] cmd_type;
    logic [6:0] level_lo;
    logic [6:0] level_hi;
    logic [7:0] time_limit;
    logic       switch_state;
    logic [2:0] channel;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   is_pop;
    logic   invalid;
    entry_t entry;
  } op_t;

endpackage

### hdl/vcf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Stands alone; no package dependency.
module vcf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hdl/vcf_front.sv
// Front end: accepts requests, checks push commands against the per-type
// rules and holds classified requests in a two-entry queue. Uses vcf_pkg.
module vcf_front (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             kind,
  input  logic [1:0]       cmd_code,
  input  logic [7:0]       level_lo,
  input  logic [7:0]       level_hi,
  input  logic [7:0]       time_limit,
  input  logic [7:0]       switch_state,
  input  logic [7:0]       channel,
  output logic             q_valid,
  output vcf_pkg::op_t     q_op,
  input  logic             q_take
);

  logic              ok;
  vcf_pkg::entry_t   entry;
  vcf_pkg::op_t      op_in;
  vcf_pkg::op_t      slot [2];
  logic [1:0]        count;
  logic              head;
  logic              push;
  logic              wr_idx;

  always_comb begin
    case (cmd_code)
      vcf_pkg::CMD_SETUP: begin
        ok = (level_lo <= vcf_pkg::LEVEL_MAX) && (level_hi <= vcf_pkg::LEVEL_MAX) &&
             (level_lo <= level_hi) && (time_limit != 8'd0) &&
             (time_limit <= vcf_pkg::TIME_MAX);
      end
      vcf_pkg::CMD_SWITCH: begin
        ok = (switch_state <= vcf_pkg::SWITCH_MAX) && (channel <= vcf_pkg::CHANNEL_MAX);
      end
      vcf_pkg::CMD_HALT: begin
        ok = 1'b1;
      end
      default: begin
        ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    entry          = '0;
    entry.cmd_type = cmd_code;
    if (cmd_code == vcf_pkg::CMD_SETUP) begin
      entry.level_lo   = level_lo[6:0];
      entry.level_hi   = level_hi[6:0];
      entry.time_limit = time_limit;
    end else if (cmd_code == vcf_pkg::CMD_SWITCH) begin
      entry.switch_state = switch_state[0];
      entry.channel      = channel[2:0];
    end
    op_in.is_pop  = (kind == vcf_pkg::KIND_POP);
    op_in.invalid = !ok;
    op_in.entry   = entry;
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign wr_idx   = (count == 2'd0) ? head : !head;
  assign q_valid  = (count != 2'd0);
  assign q_op     = slot[head];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_idx] <= op_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
      head  <= 1'b0;
    end else begin
      if (q_take) begin
        head <= !head;
      end
      if (push && !q_take) begin
        count <= count + 2'd1;
      end else if (q_take && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

### hdl/vcf_back.sv
// Back end: carries out classified pushes and pops against the command RAM,
// keeps pointers and occupancy, and holds the result register. Uses vcf_pkg
// and vcf_ram.
module vcf_back #(
  parameter int QUEUE_DEPTH = vcf_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  vcf_pkg::op_t q_op,
  output logic         q_take,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [1:0]   status,
  output logic [1:0]   out_type,
  output logic [6:0]   out_min_level,
  output logic [6:0]   out_max_level,
  output logic [7:0]   out_max_time,
  output logic         out_switch_state,
  output logic [2:0]   out_channel,
  output logic [4:0]   active_count,
  output logic [4:0]   free_count
);

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LAST_SLOT = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] FULL_OCC  = CW'(QUEUE_DEPTH);

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic            state;
  logic [AW-1:0]   rptr;
  logic [AW-1:0]   wptr;
  logic [CW-1:0]   occ;
  logic [CW-1:0]   occ_next;
  logic            out_free;
  logic            ram_we;
  logic            ram_re;
  logic [vcf_pkg::ENTRY_W-1:0] ram_rdata;
  vcf_pkg::entry_t rd_entry;
  logic [1:0]      step_status;
  logic [31:0]     act_wide;
  logic [31:0]     free_wide;

  assign out_free = !out_valid || !out_stall;
  assign q_take   = (state == ST_RUN) && q_valid && out_free;
  assign rd_entry = vcf_pkg::entry_t'(ram_rdata);

  always_comb begin
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    occ_next    = occ;
    step_status = vcf_pkg::STATUS_OK;
    if (q_op.is_pop) begin
      if (occ == '0) begin
        step_status = vcf_pkg::STATUS_EMPTY;
      end else begin
        ram_re   = q_take;
        occ_next = occ - CW'(1);
      end
    end else if (q_op.invalid) begin
      step_status = vcf_pkg::STATUS_INVALID;
    end else if (occ == FULL_OCC) begin
      step_status = vcf_pkg::STATUS_FULL;
    end else begin
      ram_we   = q_take;
      occ_next = occ + CW'(1);
    end
    act_wide  = 32'(occ_next);
    free_wide = 32'(QUEUE_DEPTH) - 32'(occ_next);
  end

  vcf_ram #(
    .WIDTH (vcf_pkg::ENTRY_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr),
    .wdata (q_op.entry),
    .re    (ram_re),
    .raddr (rptr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_RUN;
      rptr      <= '0;
      wptr      <= '0;
      occ       <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_RUN: begin
          if (q_take) begin
            occ <= occ_next;
            if (ram_we) begin
              wptr <= (wptr == LAST_SLOT) ? '0 : wptr + AW'(1);
            end
            if (ram_re) begin
              rptr      <= (rptr == LAST_SLOT) ? '0 : rptr + AW'(1);
              state     <= ST_READ;
              out_valid <= 1'b0;
            end else begin
              out_valid <= 1'b1;
            end
          end else if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
          end
        end
        ST_READ: begin
          state     <= ST_RUN;
          out_valid <= 1'b1;
        end
        default: begin
          state <= ST_RUN;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      status           <= vcf_pkg::STATUS_OK;
      out_type         <= rd_entry.cmd_type;
      out_min_level    <= rd_entry.level_lo;
      out_max_level    <= rd_entry.level_hi;
      out_max_time     <= rd_entry.time_limit;
      out_switch_state <= rd_entry.switch_state;
      out_channel      <= rd_entry.channel;
    end else if (q_take) begin
      status           <= step_status;
      out_type         <= '0;
      out_min_level    <= '0;
      out_max_level    <= '0;
      out_max_time     <= '0;
      out_switch_state <= 1'b0;
      out_channel      <= '0;
      active_count     <= act_wide[4:0];
      free_count       <= free_wide[4:0];
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (rst) occ <= FULL_OCC)
    else $error("occupancy exceeds queue depth");
  a_read_no_out: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |-> !out_valid && !q_take)
    else $error("result register busy during RAM read");
  a_read_result: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> out_valid && status == vcf_pkg::STATUS_OK)
    else $error("pop result not delivered after RAM read");
  a_re_to_read: assert property (@(posedge clk) disable iff (rst)
    ram_re |=> state == ST_READ && occ == $past(occ) - CW'(1))
    else $error("RAM read issued without entering read state");

endmodule

### hdl/validated_command_fifo.sv
// Top level of the validated command FIFO: front end, back end and result
// register. Uses vcf_pkg, vcf_front and vcf_back.
//
// Requests enter on the input channel (in_valid/in_stall) with kind selecting
// push or pop. Every request returns exactly one result on the output channel
// (out_valid/out_stall) with status, the popped command and the counts after
// the request. Only the fields a command type uses are stored; the rest pop
// as zero.
// The front end checks and queues up to two requests; the back end executes
// them in order against a RAM of QUEUE_DEPTH entries.
// A result for a push or a failed pop passes the front queue and the result
// register; a successful pop also passes the registered read of the command
// RAM, during which the back end takes no new request.
// Reset clears pointers, occupancy and both queues; no RAM clearing is done.
// When the receiver stalls, the result is held and the front queue fills,
// after which in_stall rises.
module validated_command_fifo #(
  parameter int QUEUE_DEPTH = vcf_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [1:0] cmd_code,
  input  logic [7:0] level_lo,
  input  logic [7:0] level_hi,
  input  logic [7:0] time_limit,
  input  logic [7:0] switch_state,
  input  logic [7:0] channel,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] status,
  output logic [1:0] out_type,
  output logic [6:0] out_min_level,
  output logic [6:0] out_max_level,
  output logic [7:0] out_max_time,
  output logic       out_switch_state,
  output logic [2:0] out_channel,
  output logic [4:0] active_count,
  output logic [4:0] free_count
);

  logic         q_valid;
  logic         q_take;
  vcf_pkg::op_t q_op;

  vcf_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .cmd_code     (cmd_code),
    .level_lo     (level_lo),
    .level_hi     (level_hi),
    .time_limit   (time_limit),
    .switch_state (switch_state),
    .channel      (channel),
    .q_valid      (q_valid),
    .q_op         (q_op),
    .q_take       (q_take)
  );

  vcf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_back (
    .clk              (clk),
    .rst              (rst),
    .q_valid          (q_valid),
    .q_op             (q_op),
    .q_take           (q_take),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .out_type         (out_type),
    .out_min_level    (out_min_level),
    .out_max_level    (out_max_level),
    .out_max_time     (out_max_time),
    .out_switch_state (out_switch_state),
    .out_channel      (out_channel),
    .active_count     (active_count),
    .free_count       (free_count)
  );

endmodule
